@@ hw/rtl/pitch_change_onset_detector_defines.svh @@
// Assertion macros for the RTL of the onset detector.
`ifndef PITCH_CHANGE_ONSET_DETECTOR_DEFINES_SVH
`define PITCH_CHANGE_ONSET_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PCOD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCOD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCOD_ASSERT(label, clk, rst_n, prop, msg)
`define PCOD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/pcod_pkg.sv @@
package pcod_pkg;

    localparam int PITCH_W          = 15;
    localparam int ONSET_W          = 24;
    localparam int HALF_WINDOW_DEF  = 10;
    localparam int INDEX_BITS_DEF   = 24;
    localparam int LIMIT_W          = PITCH_W + 1;

    localparam logic [PITCH_W-1:0] THRESH_RESET = PITCH_W'(128);

    typedef logic [PITCH_W-1:0] pitch_t;
    typedef logic [LIMIT_W-1:0] limit_t;

endpackage

@@ hw/rtl/pitch_change_onset_detector.sv @@
// Pitch-change onset detector.
// Pitch frames (Q7.8 semitones, zero for unvoiced) enter on the s_ channel;
// detected onset frame indexes leave on the m_ channel, zero or one per frame.
// The change threshold is written on the cfg_ channel, which is always ready
// and should be written only while the block is idle.
// A frame that arrives before the window of 2*HALF_WINDOW frames is full is
// stored in the transaction cycle and the block is ready again at once.
// Once the window is full, each frame is accepted, the voiced frames in the
// window are counted, the median is built one bit at a time from the top bit,
// and the median is compared against the current note. A window with no voiced
// frame skips the median search.
// A single ranking unit compares every window entry against a trial value.
// An onset is held in an output register until m_tready takes it; new frames
// are accepted meanwhile, and the block waits in its final step only when a
// second onset is due while the first is still not taken.
// Reset clears the frame counter, the current note, the last onset index, the
// output valid flag and sets the threshold to 0.5 semitone (128).
module pitch_change_onset_detector #(
    parameter int HALF_WINDOW = pcod_pkg::HALF_WINDOW_DEF,
    parameter int INDEX_BITS  = pcod_pkg::INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [14:0] pitch_sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,   // [23:0] onset_index
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pcod_pkg::PITCH_W-1:0] cfg_data  // [14:0] change_threshold
);
    import pcod_pkg::*;

`include "pitch_change_onset_detector_defines.svh"

    localparam int DEPTH  = 2 * HALF_WINDOW;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX1_W = INDEX_BITS + 1;
    localparam int BIT_W  = $clog2(PITCH_W);

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_SEARCH,
        S_DECIDE
    } state_t;

    state_t                 state_reg, state_next;
    pitch_t                 win_reg [DEPTH];
    logic [PTR_W-1:0]       wp_reg, wp_next;
    pitch_t                 sample_reg, sample_next;
    logic [INDEX_BITS-1:0]  count_reg, count_next;
    pitch_t                 note_reg, note_next;
    logic [INDEX_BITS-1:0]  last_onset_reg, last_onset_next;
    pitch_t                 thresh_reg, thresh_next;
    pitch_t                 med_reg, med_next;
    logic [CNT_W-1:0]       rank_reg, rank_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ONSET_W-1:0]     out_data_reg, out_data_next;

    logic                   win_we;
    pitch_t                 win_wdata;
    limit_t                 trial;
    limit_t                 limit;
    logic [CNT_W-1:0]       rank_cnt;
    logic [INDEX_BITS-1:0]  idx;
    pitch_t                 diff;
    logic                   out_busy;

    assign trial = {1'b0, med_reg} | (LIMIT_W'(1) << bit_reg);
    assign limit = (state_reg == S_COUNT) ? (LIMIT_W'(1) << PITCH_W) : trial;

    pcod_rank_count #(
        .DEPTH (DEPTH)
    ) u_rank (
        .win   (win_reg),
        .limit (limit),
        .count (rank_cnt)
    );

    assign idx      = count_reg - INDEX_BITS'(HALF_WINDOW);
    assign diff     = (med_reg >= note_reg) ? (med_reg - note_reg) : (note_reg - med_reg);
    assign out_busy = out_valid_reg && !m_tready;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        sample_next     = sample_reg;
        count_next      = count_reg;
        note_next       = note_reg;
        last_onset_next = last_onset_reg;
        thresh_next     = thresh_reg;
        med_next        = med_reg;
        rank_next       = rank_reg;
        bit_next        = bit_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        win_we          = 1'b0;
        win_wdata       = sample_reg;

        if (cfg_valid)
        begin
            thresh_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                sample_next = s_tdata[PITCH_W-1:0];
                win_wdata   = s_tdata[PITCH_W-1:0];
                if (s_tvalid)
                begin
                    if (count_reg >= INDEX_BITS'(DEPTH))
                    begin
                        state_next = S_COUNT;
                    end
                    else
                    begin
                        win_we     = 1'b1;
                        count_next = count_reg + INDEX_BITS'(1);
                        wp_next    = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                    end
                end
            end
            S_COUNT:
            begin
                rank_next = rank_cnt >> 1;
                med_next  = '0;
                bit_next  = BIT_W'(PITCH_W - 1);
                state_next = (rank_cnt == '0) ? S_DECIDE : S_SEARCH;
            end
            S_SEARCH:
            begin
                // Keep the trial bit while no more than rank entries lie below it.
                if (rank_cnt <= rank_reg)
                begin
                    med_next = trial[PITCH_W-1:0];
                end
                if (bit_reg == '0)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            S_DECIDE:
            begin
                if (diff > thresh_reg &&
                    {1'b0, idx} > ({1'b0, last_onset_reg} + IDX1_W'(HALF_WINDOW)))
                begin
                    if (!out_busy)
                    begin
                        note_next       = med_reg;
                        last_onset_next = idx;
                        out_valid_next  = 1'b1;
                        out_data_next   = ONSET_W'(idx);
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    if (diff > thresh_reg)
                    begin
                        note_next = med_reg;
                    end
                    state_next = S_IDLE;
                end
                if (state_next == S_IDLE)
                begin
                    win_we     = 1'b1;
                    count_next = (count_reg < COUNT_MAX) ? count_reg + INDEX_BITS'(1)
                                                         : count_reg;
                    wp_next    = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wp_reg         <= '0;
            count_reg      <= '0;
            note_reg       <= '0;
            last_onset_reg <= '0;
            thresh_reg     <= THRESH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            note_reg       <= note_next;
            last_onset_reg <= last_onset_next;
            thresh_reg     <= thresh_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        med_reg      <= med_next;
        rank_reg     <= rank_next;
        bit_reg      <= bit_next;
        out_data_reg <= out_data_next;
        if (win_we)
        begin
            win_reg[wp_reg] <= win_wdata;
        end
    end

    // In the idle state the window stores the sample straight from the port.

    `PCOD_ASSERT(a_out_from_decide, clk, rst_n,
        $rose(m_tvalid) |-> $past(state_reg == S_DECIDE),
        "Onset transaction started outside the decision step.")
    `PCOD_ASSERT(a_onset_matches_output, clk, rst_n,
        !$stable(last_onset_reg) |-> (m_tvalid && m_tdata == ONSET_W'(last_onset_reg)),
        "Last onset index changed without a matching output transaction.")
    `PCOD_ASSERT(a_full_window_evaluates, clk, rst_n,
        (s_tvalid && s_tready && count_reg >= INDEX_BITS'(DEPTH)) |=> (state_reg == S_COUNT),
        "Frame with a full window skipped the evaluation.")
    `PCOD_ASSERT_ALWAYS(a_reset_idle, clk,
        !rst_n |-> (state_reg == S_IDLE && !m_tvalid),
        "Block not idle during reset.")

endmodule

@@ hw/rtl/pcod_rank_count.sv @@
module pcod_rank_count #(
    parameter int DEPTH = 2 * pcod_pkg::HALF_WINDOW_DEF
) (
    input  pcod_pkg::pitch_t             win [DEPTH],
    input  pcod_pkg::limit_t             limit,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import pcod_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Counts the voiced entries whose value lies strictly below the limit.
    always_comb
    begin
        count = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((win[i] != '0) && ({1'b0, win[i]} < limit))
            begin
                count = count + CNT_W'(1);
            end
        end
    end

endmodule
